/* rtl/kvt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// kvt_pkg
// Shared types and constants for the key/value text tokeniser.
// ============================================================================
package kvt_pkg;

    // token category codes
    typedef enum logic [3:0] {
        CAT_EOF    = 4'd0,
        CAT_KEY    = 4'd1,
        CAT_NULL   = 4'd2,
        CAT_STRING = 4'd3,
        CAT_CHAR   = 4'd4,
        CAT_INT    = 4'd5,
        CAT_FLOAT  = 4'd6,
        CAT_DOUBLE = 4'd7,
        CAT_BOOL   = 4'd8,
        CAT_LBRACK = 4'd9,
        CAT_RBRACK = 4'd10,
        CAT_SEMI   = 4'd11,
        CAT_COLON  = 4'd12,
        CAT_COMMA  = 4'd13
    } cat_e;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_INVALID_CHAR  = 3'd1,
        ERR_STR_UNCLOSED  = 3'd2,
        ERR_CHAR_UNCLOSED = 3'd3,
        ERR_BAD_ESCAPE    = 3'd4,
        ERR_DOUBLE_DOT    = 3'd5
    } err_e;

    // one result word
    typedef struct packed {
        cat_e        category;
        err_e        error_code;
        logic [15:0] line_number;
        logic [15:0] start_column;
        logic [11:0] token_length;
        logic        end_of_text;
        logic        end_of_run;
    } result_t;

    // character class flags of one byte
    typedef struct packed {
        logic space;    // space, tab, CR or LF
        logic newline;
        logic hash;
        logic alpha;
        logic digit;
        logic under;
        logic delim;
        cat_e delim_cat;
        logic dquote;
        logic squote;
        logic bslash;
        logic dot;
        logic minus;
        logic suffix_f;
        logic suffix_d;
    } class_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keyword spellings, one character per index
    function automatic logic [7:0] kw_true_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = "t";
            2'd1:    c = "r";
            2'd2:    c = "u";
            default: c = "e";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_false_char(input logic [2:0] i);
        logic [7:0] c;
        case (i)
            3'd0:    c = "f";
            3'd1:    c = "a";
            3'd2:    c = "l";
            3'd3:    c = "s";
            default: c = "e";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_null_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = "n";
            2'd1:    c = "u";
            default: c = "l";
        endcase
        return c;
    endfunction

endpackage

/* rtl/kvt_classify.sv */
`timescale 1ns / 1ps
// ============================================================================
// kvt_classify
// Decodes one text byte into character class flags.
// ============================================================================
module kvt_classify (
    input  logic [7:0]      text_byte,
    output kvt_pkg::class_t cls
);

    always_comb begin
        cls = '0;
        cls.newline  = (text_byte == kvt_pkg::CH_LF);
        cls.space    = (text_byte == kvt_pkg::CH_SPACE) || (text_byte == kvt_pkg::CH_TAB) ||
                       (text_byte == kvt_pkg::CH_CR)    || (text_byte == kvt_pkg::CH_LF);
        cls.hash     = (text_byte == kvt_pkg::CH_HASH);
        cls.alpha    = ((text_byte >= "a") && (text_byte <= "z")) ||
                       ((text_byte >= "A") && (text_byte <= "Z"));
        cls.digit    = (text_byte >= "0") && (text_byte <= "9");
        cls.under    = (text_byte == kvt_pkg::CH_UNDER);
        cls.dquote   = (text_byte == kvt_pkg::CH_DQUOTE);
        cls.squote   = (text_byte == kvt_pkg::CH_SQUOTE);
        cls.bslash   = (text_byte == kvt_pkg::CH_BSLASH);
        cls.dot      = (text_byte == kvt_pkg::CH_DOT);
        cls.minus    = (text_byte == kvt_pkg::CH_MINUS);
        cls.suffix_f = (text_byte == "f") || (text_byte == "F");
        cls.suffix_d = (text_byte == "d") || (text_byte == "D");

        cls.delim     = 1'b1;
        cls.delim_cat = kvt_pkg::CAT_EOF;
        unique case (text_byte)
            kvt_pkg::CH_LBRACK: cls.delim_cat = kvt_pkg::CAT_LBRACK;
            kvt_pkg::CH_RBRACK: cls.delim_cat = kvt_pkg::CAT_RBRACK;
            kvt_pkg::CH_SEMI:   cls.delim_cat = kvt_pkg::CAT_SEMI;
            kvt_pkg::CH_COLON:  cls.delim_cat = kvt_pkg::CAT_COLON;
            kvt_pkg::CH_COMMA:  cls.delim_cat = kvt_pkg::CAT_COMMA;
            default:            cls.delim     = 1'b0;
        endcase
    end

endmodule

/* rtl/kvt_scan.sv */
`timescale 1ns / 1ps
// ============================================================================
// kvt_scan
// Scanner state and the per-byte step: next state plus up to three results.
// ============================================================================
module kvt_scan #(
    parameter int POSITION_BITS    = 16,
    parameter int MAX_TOKEN_LENGTH = 4095,
    parameter int CW               = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      commit,
    input  logic [7:0]                text_byte,
    input  logic                      final_byte,
    input  kvt_pkg::class_t           cls,
    output kvt_pkg::result_t [2:0]    res_out,
    output logic [1:0]                res_count
);

    localparam int PB = POSITION_BITS;

    typedef enum logic [2:0] {
        M_IDLE       = 3'd0,
        M_COMMENT    = 3'd1,
        M_KEY        = 3'd2,
        M_STRING     = 3'd3,
        M_CHAR_OPEN  = 3'd4,
        M_CHAR_ESC   = 3'd5,
        M_CHAR_CLOSE = 3'd6,
        M_NUMBER     = 3'd7
    } mode_e;

    typedef struct packed {
        mode_e          mode;
        logic [PB-1:0]  line;
        logic [PB-1:0]  col;
        logic [PB-1:0]  tstart;
        logic [CW-1:0]  cnt;
        logic           prev_bs;
        logic [2:0]     nflags;   // bit0 dot, bit1 f, bit2 d
        logic [2:0]     kw;       // bit0 true, bit1 false, bit2 null
        logic           halted;
    } scan_state_t;

    scan_state_t st_reg;
    scan_state_t st_next;

    function automatic scan_state_t rst_state();
        scan_state_t q;
        q         = '0;
        q.mode    = M_IDLE;
        q.line    = PB'(1);
        return q;
    endfunction

    function automatic logic [15:0] clip_pos(input logic [PB-1:0] v);
        logic [PB+15:0] w;
        w = {16'd0, v};
        if (w > (PB+16)'(16'hFFFF)) return 16'hFFFF;
        return w[15:0];
    endfunction

    function automatic logic [11:0] clip_len(input logic [CW-1:0] v);
        logic [CW+11:0] w;
        w = {12'd0, v};
        if (w > (CW+12)'(4095)) return 12'hFFF;
        return w[11:0];
    endfunction

    function automatic kvt_pkg::result_t mk_res(input kvt_pkg::cat_e cat,
                                                input kvt_pkg::err_e e,
                                                input logic eof_pos,
                                                input scan_state_t s);
        kvt_pkg::result_t q;
        logic             is_err;
        is_err         = (e != kvt_pkg::ERR_NONE);
        q.category     = cat;
        q.error_code   = e;
        q.line_number  = eof_pos ? 16'd0 : clip_pos(s.line);
        q.start_column = eof_pos ? 16'd0 : clip_pos(is_err ? s.col : s.tstart);
        q.token_length = (is_err || eof_pos) ? 12'd0 : clip_len(s.cnt);
        q.end_of_text  = eof_pos || is_err;
        q.end_of_run   = 1'b0;
        return q;
    endfunction

    function automatic kvt_pkg::cat_e key_cat(input scan_state_t s);
        if ((s.cnt == CW'(4)) && s.kw[0]) return kvt_pkg::CAT_BOOL;
        if ((s.cnt == CW'(5)) && s.kw[1]) return kvt_pkg::CAT_BOOL;
        if ((s.cnt == CW'(4)) && s.kw[2]) return kvt_pkg::CAT_NULL;
        return kvt_pkg::CAT_KEY;
    endfunction

    function automatic kvt_pkg::cat_e num_cat(input logic [2:0] f);
        if (f[1]) return kvt_pkg::CAT_FLOAT;
        if (f[0] || f[2]) return kvt_pkg::CAT_DOUBLE;
        return kvt_pkg::CAT_INT;
    endfunction

    always_comb begin
        scan_state_t            s;
        kvt_pkg::result_t [2:0] r;
        logic [1:0]             n;
        kvt_pkg::err_e          err;
        logic                   again;

        s     = st_reg;
        r     = '0;
        n     = 2'd0;
        err   = kvt_pkg::ERR_NONE;
        again = 1'b0;

        if (st_reg.halted) begin
            if (final_byte) begin
                s = rst_state();
            end
        end else begin
            if (s.col != {PB{1'b1}}) begin
                s.col = s.col + PB'(1);
            end

            // first look at the byte in the open token's mode
            unique case (st_reg.mode)
                M_IDLE: begin
                end
                M_COMMENT: begin
                    if (cls.newline) begin
                        if (s.line != {PB{1'b1}}) s.line = s.line + PB'(1);
                        s.col  = '0;
                        s.mode = M_IDLE;
                    end
                end
                M_KEY: begin
                    if (cls.alpha || cls.digit || cls.under) begin
                        if (!((s.cnt < CW'(4)) && (text_byte == kvt_pkg::kw_true_char(s.cnt[1:0]))))
                            s.kw[0] = 1'b0;
                        if (!((s.cnt < CW'(5)) && (text_byte == kvt_pkg::kw_false_char(s.cnt[2:0]))))
                            s.kw[1] = 1'b0;
                        if (!((s.cnt < CW'(4)) && (text_byte == kvt_pkg::kw_null_char(s.cnt[1:0]))))
                            s.kw[2] = 1'b0;
                        if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                    end else begin
                        r[n]   = mk_res(key_cat(s), kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                        s.mode = M_IDLE;
                        again  = 1'b1;
                    end
                end
                M_STRING: begin
                    if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                    if (cls.dquote && !s.prev_bs) begin
                        r[n]   = mk_res(kvt_pkg::CAT_STRING, kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                        s.mode = M_IDLE;
                    end else begin
                        s.prev_bs = cls.bslash;
                    end
                end
                M_CHAR_OPEN: begin
                    if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                    s.mode = cls.bslash ? M_CHAR_ESC : M_CHAR_CLOSE;
                end
                M_CHAR_ESC: begin
                    if (cls.squote) begin
                        if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                        s.mode = M_CHAR_CLOSE;
                    end else begin
                        err = kvt_pkg::ERR_BAD_ESCAPE;
                    end
                end
                M_CHAR_CLOSE: begin
                    if (cls.squote) begin
                        if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                        r[n]   = mk_res(kvt_pkg::CAT_CHAR, kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                        s.mode = M_IDLE;
                    end else begin
                        err = kvt_pkg::ERR_CHAR_UNCLOSED;
                    end
                end
                M_NUMBER: begin
                    if (cls.digit) begin
                        if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                    end else if (cls.dot) begin
                        if (s.nflags[0]) begin
                            err = kvt_pkg::ERR_DOUBLE_DOT;
                        end else begin
                            s.nflags[0] = 1'b1;
                            if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                        end
                    end else if (cls.suffix_f || cls.suffix_d) begin
                        if (cls.suffix_f) s.nflags[1] = 1'b1;
                        else              s.nflags[2] = 1'b1;
                        if (s.cnt < CW'(MAX_TOKEN_LENGTH)) s.cnt = s.cnt + CW'(1);
                        r[n]   = mk_res(num_cat(s.nflags), kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                        s.mode = M_IDLE;
                    end else begin
                        r[n]   = mk_res(num_cat(s.nflags), kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                        s.mode = M_IDLE;
                        again  = 1'b1;
                    end
                end
            endcase

            // idle: the byte opens a token (or a terminator is judged again)
            if ((st_reg.mode == M_IDLE) || again) begin
                if (cls.space) begin
                    if (cls.newline) begin
                        if (s.line != {PB{1'b1}}) s.line = s.line + PB'(1);
                        s.col = '0;
                    end
                end else if (cls.hash) begin
                    s.mode = M_COMMENT;
                end else if (cls.alpha || cls.under || cls.delim || cls.dquote ||
                             cls.squote || cls.digit || cls.dot || cls.minus) begin
                    s.tstart  = s.col;
                    s.cnt     = CW'(1);
                    s.prev_bs = 1'b0;
                    s.nflags  = 3'b000;
                    s.kw      = 3'b000;
                    if (cls.alpha || cls.under) begin
                        s.mode = M_KEY;
                        s.kw   = {text_byte == kvt_pkg::kw_null_char(2'd0),
                                  text_byte == kvt_pkg::kw_false_char(3'd0),
                                  text_byte == kvt_pkg::kw_true_char(2'd0)};
                    end else if (cls.delim) begin
                        s.mode = M_IDLE;
                        r[n]   = mk_res(cls.delim_cat, kvt_pkg::ERR_NONE, 1'b0, s);
                        n      = n + 2'd1;
                    end else if (cls.dquote) begin
                        s.mode = M_STRING;
                    end else if (cls.squote) begin
                        s.mode = M_CHAR_OPEN;
                    end else begin
                        s.mode      = M_NUMBER;
                        s.nflags[0] = cls.dot;
                    end
                end else begin
                    err = kvt_pkg::ERR_INVALID_CHAR;
                end
            end

            // end of text: flush an open key or number, then EOF or an error
            if ((err == kvt_pkg::ERR_NONE) && final_byte) begin
                unique case (s.mode) inside
                    M_KEY: begin
                        r[n] = mk_res(key_cat(s), kvt_pkg::ERR_NONE, 1'b0, s);
                        n    = n + 2'd1;
                    end
                    M_NUMBER: begin
                        r[n] = mk_res(num_cat(s.nflags), kvt_pkg::ERR_NONE, 1'b0, s);
                        n    = n + 2'd1;
                    end
                    M_STRING: err = kvt_pkg::ERR_STR_UNCLOSED;
                    M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: err = kvt_pkg::ERR_CHAR_UNCLOSED;
                    default: begin
                    end
                endcase
                if (err == kvt_pkg::ERR_NONE) begin
                    r[n] = mk_res(kvt_pkg::CAT_EOF, kvt_pkg::ERR_NONE, 1'b1, s);
                    n    = n + 2'd1;
                end
            end
            if (err != kvt_pkg::ERR_NONE) begin
                r[n]     = mk_res(kvt_pkg::CAT_EOF, err, 1'b0, s);
                n        = n + 2'd1;
                s.halted = 1'b1;
            end
            if (final_byte) begin
                s = rst_state();
            end
            if (n != 2'd0) begin
                r[n - 2'd1].end_of_run = 1'b1;
            end
        end

        st_next   = s;
        res_out   = r;
        res_count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= rst_state();
        end else if (commit) begin
            st_reg <= st_next;
        end
    end

endmodule

/* rtl/kvt_outbuf.sv */
`timescale 1ns / 1ps
// ============================================================================
// kvt_outbuf
// Holds one byte's result words; one leaves per cycle while m_ready is high.
// ============================================================================
module kvt_outbuf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [1:0]             load_count,
    input  kvt_pkg::result_t [2:0] load_res,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output kvt_pkg::result_t       m_res
);

    kvt_pkg::result_t bnd_reg [3];
    logic [1:0]       left_reg;
    logic [1:0]       idx_reg;

    assign m_valid = (left_reg != 2'd0);
    assign m_res   = bnd_reg[idx_reg];
    // room once the last held word leaves this cycle
    assign free    = (left_reg == 2'd0) || ((left_reg == 2'd1) && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end else if (load) begin
            left_reg <= load_count;
            idx_reg  <= 2'd0;
        end else if (m_valid && m_ready) begin
            left_reg <= left_reg - 2'd1;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bnd_reg[0] <= load_res[0];
            bnd_reg[1] <= load_res[1];
            bnd_reg[2] <= load_res[2];
        end
    end

endmodule

/* rtl/key_value_text_tokenizer.sv */
`timescale 1ns / 1ps
// ============================================================================
// key_value_text_tokenizer
// Streaming lexer for a key/value text format: one byte in, zero to three
// token words out.
// ============================================================================
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-------------------------------------------
//  s_      | in  | s_valid/s_ready | s_text_byte, s_final_byte
//  m_      | out | m_valid/m_ready | seven token fields, m_category..m_end_of_run
//
//  Input register, class decode, scanner step; one byte per cycle unless stalled.
//  A taken byte sits in the input register until the buffer takes its words.
//  A byte giving k words loads them into a three-word buffer.
//  Any byte waits while two or more words are held, or one is and m_ready is low.
//  s_ready comes from a skid register and never follows m_ready in the same cycle.
//  Reset (aresetn low, synchronous): line 1, column 0, idle, all stages empty.
//
module key_value_text_tokenizer #(
    parameter int MAX_TOKEN_LENGTH = 4095,
    parameter int POSITION_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_final_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_category,
    output logic [2:0]  m_error_code,
    output logic [15:0] m_line_number,
    output logic [15:0] m_start_column,
    output logic [11:0] m_token_length,
    output logic        m_end_of_text,
    output logic        m_end_of_run
);

    // token length counter must hold MAX_TOKEN_LENGTH itself
    localparam int CW = $clog2(MAX_TOKEN_LENGTH + 1);

    // input register and skid register
    logic       a_valid_reg, a_valid_next;
    logic [7:0] a_byte_reg,  a_byte_next;
    logic       a_fin_reg,   a_fin_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] skid_byte_reg,  skid_byte_next;
    logic       skid_fin_reg,   skid_fin_next;

    logic                   take;
    logic                   commit;
    logic                   buf_free;
    kvt_pkg::class_t        cls;
    kvt_pkg::result_t [2:0] step_res;
    logic [1:0]             step_count;
    kvt_pkg::result_t       out_res;

    assign s_ready = !skid_valid_reg;
    assign take    = s_valid && s_ready;
    // a byte is scanned once the result buffer can take all its words
    assign commit  = a_valid_reg && buf_free;

    always_comb begin
        a_valid_next    = a_valid_reg;
        a_byte_next     = a_byte_reg;
        a_fin_next      = a_fin_reg;
        skid_valid_next = skid_valid_reg;
        skid_byte_next  = skid_byte_reg;
        skid_fin_next   = skid_fin_reg;
        if (!a_valid_reg || commit) begin
            if (skid_valid_reg) begin
                a_valid_next    = 1'b1;
                a_byte_next     = skid_byte_reg;
                a_fin_next      = skid_fin_reg;
                skid_valid_next = 1'b0;
            end else begin
                a_valid_next = take;
                a_byte_next  = s_text_byte;
                a_fin_next   = s_final_byte;
            end
        end else if (take) begin
            // input register stalled: park the word
            skid_valid_next = 1'b1;
            skid_byte_next  = s_text_byte;
            skid_fin_next   = s_final_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            a_valid_reg    <= a_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_byte_reg    <= a_byte_next;
        a_fin_reg     <= a_fin_next;
        skid_byte_reg <= skid_byte_next;
        skid_fin_reg  <= skid_fin_next;
    end

    kvt_classify u_classify (
        .text_byte (a_byte_reg),
        .cls       (cls)
    );

    kvt_scan #(
        .POSITION_BITS    (POSITION_BITS),
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .CW               (CW)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (commit),
        .text_byte  (a_byte_reg),
        .final_byte (a_fin_reg),
        .cls        (cls),
        .res_out    (step_res),
        .res_count  (step_count)
    );

    kvt_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (commit),
        .load_count (step_count),
        .load_res   (step_res),
        .free       (buf_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (out_res)
    );

    assign m_category     = out_res.category;
    assign m_error_code   = out_res.error_code;
    assign m_line_number  = out_res.line_number;
    assign m_start_column = out_res.start_column;
    assign m_token_length = out_res.token_length;
    assign m_end_of_text  = out_res.end_of_text;
    assign m_end_of_run   = out_res.end_of_run;

    // EOF and error words always close their byte's run
    a_eot_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_text |-> m_end_of_run)
        else $error("end_of_text word not last of its run");

    // error words carry no category and no length
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != kvt_pkg::ERR_NONE) |->
            (m_category == kvt_pkg::CAT_EOF) && (m_token_length == 12'd0) && m_end_of_text)
        else $error("malformed error word");

    // real tokens always sit at line and column 1 or later, with nonzero length
    a_token_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_category != kvt_pkg::CAT_EOF) |->
            (m_line_number != 16'd0) && (m_start_column != 16'd0) && (m_token_length != 12'd0))
        else $error("token with zero position or length");

    // skid only fills behind a held input register
    a_skid_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> a_valid_reg)
        else $error("skid register full with input register empty");

endmodule

/* verif/key_value_text_tokenizer_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// key_value_text_tokenizer_tb
// Self-checking bench for the streaming key/value tokeniser. Directed texts
// cover each token kind and every error; random texts follow. A scoreboard
// compares every result word with a predictor.
// ============================================================================
module key_value_text_tokenizer_tb;

    localparam int LIMIT_CYCLES  = 50_000;
    localparam int RANDOM_BYTES  = 60;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTS    = 40;

    // scanner modes of the predictor
    typedef enum logic [2:0] {
        SC_IDLE, SC_COMMENT, SC_KEY, SC_STRING,
        SC_CHAR_OPEN, SC_CHAR_ESC, SC_CHAR_CLOSE, SC_NUMBER
    } scan_e;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_text_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_category;
    logic [2:0]  m_error_code;
    logic [15:0] m_line_number;
    logic [15:0] m_start_column;
    logic [11:0] m_token_length;
    logic        m_end_of_text;
    logic        m_end_of_run;

    // predictor state, mirrors the scanner registers
    scan_e       sc_mode;
    logic [15:0] sc_line;
    logic [15:0] sc_col;
    logic [15:0] sc_tok_col;
    logic [11:0] sc_len;
    logic        sc_bslash;
    logic [2:0]  sc_num;     // bit0 dot, bit1 f, bit2 d
    logic [2:0]  sc_kw;      // bit0 true, bit1 false, bit2 null still possible
    logic        sc_halted;

    kvt_pkg::result_t step_words[$];
    kvt_pkg::result_t expected_tokens[$];
    logic [7:0]       text_bytes[$];

    int          mismatch_count;
    int          tokens_checked;
    int          bytes_sent;
    int          texts_sent;
    int          cycle_count;

    key_value_text_tokenizer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_category     (m_category),
        .m_error_code   (m_error_code),
        .m_line_number  (m_line_number),
        .m_start_column (m_start_column),
        .m_token_length (m_token_length),
        .m_end_of_text  (m_end_of_text),
        .m_end_of_run   (m_end_of_run)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // i-th letter of an n-letter keyword, zero past its end
    function automatic logic [7:0] spell(input logic [39:0] w, input int n, input int i);
        return (i < n) ? w[8*(n-i-1) +: 8] : 8'h00;
    endfunction

    function automatic void clear_state();
        sc_mode    = SC_IDLE;
        sc_line    = 16'd1;
        sc_col     = '0;
        sc_tok_col = '0;
        sc_len     = '0;
        sc_bslash  = 1'b0;
        sc_num     = '0;
        sc_kw      = '0;
        sc_halted  = 1'b0;
    endfunction

    function automatic void new_line();
        if (sc_line != 16'hFFFF) sc_line++;
        sc_col = '0;
    endfunction

    function automatic void start_token(input scan_e mode);
        sc_tok_col = sc_col;
        sc_len     = 12'd1;
        sc_bslash  = 1'b0;
        sc_num     = '0;
        sc_kw      = '0;
        sc_mode    = mode;
    endfunction

    function automatic void grow();
        if (sc_len != 12'hFFF) sc_len++;
    endfunction

    function automatic void match_keyword(input logic [7:0] c, input int idx);
        if (spell("true", 4, idx) != c)  sc_kw[0] = 1'b0;
        if (spell("false", 5, idx) != c) sc_kw[1] = 1'b0;
        if (spell("null", 4, idx) != c)  sc_kw[2] = 1'b0;
    endfunction

    function automatic kvt_pkg::cat_e key_cat();
        if (sc_len == 12'd4 && sc_kw[0]) return kvt_pkg::CAT_BOOL;
        if (sc_len == 12'd5 && sc_kw[1]) return kvt_pkg::CAT_BOOL;
        if (sc_len == 12'd4 && sc_kw[2]) return kvt_pkg::CAT_NULL;
        return kvt_pkg::CAT_KEY;
    endfunction

    function automatic kvt_pkg::cat_e number_cat();
        if (sc_num[1]) return kvt_pkg::CAT_FLOAT;
        if (sc_num[0] || sc_num[2]) return kvt_pkg::CAT_DOUBLE;
        return kvt_pkg::CAT_INT;
    endfunction

    // errors and EOF carry end_of_text; errors report the current column
    function automatic void push_word(input kvt_pkg::cat_e cat, input kvt_pkg::err_e err,
                                      input bit eof_pos);
        kvt_pkg::result_t w;
        w.category     = cat;
        w.error_code   = err;
        w.line_number  = eof_pos ? 16'd0 : sc_line;
        w.start_column = eof_pos ? 16'd0 :
                         ((err != kvt_pkg::ERR_NONE) ? sc_col : sc_tok_col);
        w.token_length = (eof_pos || err != kvt_pkg::ERR_NONE) ? 12'd0 : sc_len;
        w.end_of_text  = eof_pos || (err != kvt_pkg::ERR_NONE);
        w.end_of_run   = 1'b0;
        step_words     = {step_words, w};
    endfunction

    // scans one accepted byte and queues the words it should produce
    function automatic void tokenise_byte(input logic [7:0] c, input logic fin);
        kvt_pkg::err_e err;
        bit            again;
        int            pass;
        kvt_pkg::cat_e dcat;
        err   = kvt_pkg::ERR_NONE;
        again = 1'b1;
        step_words.delete();
        if (sc_halted) begin
            if (fin) clear_state();
            return;
        end
        if (sc_col != 16'hFFFF) sc_col++;

        // a terminator of a key or number is judged a second time
        for (pass = 0; pass < 2 && again && err == kvt_pkg::ERR_NONE; pass++) begin
            again = 1'b0;
            case (sc_mode)
                SC_IDLE: begin
                    if (c == kvt_pkg::CH_SPACE || c == kvt_pkg::CH_TAB ||
                        c == kvt_pkg::CH_CR || c == kvt_pkg::CH_LF) begin
                        if (c == kvt_pkg::CH_LF) new_line();
                    end else if (c == kvt_pkg::CH_HASH) begin
                        sc_mode = SC_COMMENT;
                    end else if (is_alpha(c) || c == kvt_pkg::CH_UNDER) begin
                        start_token(SC_KEY);
                        sc_kw = 3'b111;
                        match_keyword(c, 0);
                    end else if (c == kvt_pkg::CH_LBRACK || c == kvt_pkg::CH_RBRACK ||
                                 c == kvt_pkg::CH_SEMI || c == kvt_pkg::CH_COLON ||
                                 c == kvt_pkg::CH_COMMA) begin
                        case (c)
                            kvt_pkg::CH_LBRACK: dcat = kvt_pkg::CAT_LBRACK;
                            kvt_pkg::CH_RBRACK: dcat = kvt_pkg::CAT_RBRACK;
                            kvt_pkg::CH_SEMI:   dcat = kvt_pkg::CAT_SEMI;
                            kvt_pkg::CH_COLON:  dcat = kvt_pkg::CAT_COLON;
                            default:            dcat = kvt_pkg::CAT_COMMA;
                        endcase
                        start_token(SC_IDLE);
                        push_word(dcat, kvt_pkg::ERR_NONE, 1'b0);
                    end else if (c == kvt_pkg::CH_DQUOTE) begin
                        start_token(SC_STRING);
                    end else if (c == kvt_pkg::CH_SQUOTE) begin
                        start_token(SC_CHAR_OPEN);
                    end else if (is_digit(c) || c == kvt_pkg::CH_DOT ||
                                 c == kvt_pkg::CH_MINUS) begin
                        start_token(SC_NUMBER);
                        sc_num = (c == kvt_pkg::CH_DOT) ? 3'b001 : 3'b000;
                    end else begin
                        err = kvt_pkg::ERR_INVALID_CHAR;
                    end
                end
                SC_COMMENT: begin
                    if (c == kvt_pkg::CH_LF) begin
                        new_line();
                        sc_mode = SC_IDLE;
                    end
                end
                SC_KEY: begin
                    if (is_alpha(c) || is_digit(c) || c == kvt_pkg::CH_UNDER) begin
                        match_keyword(c, sc_len);
                        grow();
                    end else begin
                        push_word(key_cat(), kvt_pkg::ERR_NONE, 1'b0);
                        sc_mode = SC_IDLE;
                        again   = 1'b1;
                    end
                end
                SC_STRING: begin
                    grow();
                    // any backslash escapes the quote after it, even an escaped one
                    if (c == kvt_pkg::CH_DQUOTE && !sc_bslash) begin
                        push_word(kvt_pkg::CAT_STRING, kvt_pkg::ERR_NONE, 1'b0);
                        sc_mode = SC_IDLE;
                    end else begin
                        sc_bslash = (c == kvt_pkg::CH_BSLASH);
                    end
                end
                SC_CHAR_OPEN: begin
                    grow();
                    sc_mode = (c == kvt_pkg::CH_BSLASH) ? SC_CHAR_ESC : SC_CHAR_CLOSE;
                end
                SC_CHAR_ESC: begin
                    if (c == kvt_pkg::CH_SQUOTE) begin
                        grow();
                        sc_mode = SC_CHAR_CLOSE;
                    end else begin
                        err = kvt_pkg::ERR_BAD_ESCAPE;
                    end
                end
                SC_CHAR_CLOSE: begin
                    if (c == kvt_pkg::CH_SQUOTE) begin
                        grow();
                        push_word(kvt_pkg::CAT_CHAR, kvt_pkg::ERR_NONE, 1'b0);
                        sc_mode = SC_IDLE;
                    end else begin
                        err = kvt_pkg::ERR_CHAR_UNCLOSED;
                    end
                end
                default: begin
                    if (is_digit(c)) begin
                        grow();
                    end else if (c == kvt_pkg::CH_DOT) begin
                        if (sc_num[0]) begin
                            err = kvt_pkg::ERR_DOUBLE_DOT;
                        end else begin
                            sc_num[0] = 1'b1;
                            grow();
                        end
                    end else if (c == "f" || c == "F" || c == "d" || c == "D") begin
                        if (c == "f" || c == "F") sc_num[1] = 1'b1;
                        else sc_num[2] = 1'b1;
                        grow();
                        push_word(number_cat(), kvt_pkg::ERR_NONE, 1'b0);
                        sc_mode = SC_IDLE;
                    end else begin
                        push_word(number_cat(), kvt_pkg::ERR_NONE, 1'b0);
                        sc_mode = SC_IDLE;
                        again   = 1'b1;
                    end
                end
            endcase
        end

        // end of text: flush the open token, then EOF unless something failed
        if (err == kvt_pkg::ERR_NONE && fin) begin
            case (sc_mode) inside
                SC_KEY:    push_word(key_cat(), kvt_pkg::ERR_NONE, 1'b0);
                SC_NUMBER: push_word(number_cat(), kvt_pkg::ERR_NONE, 1'b0);
                SC_STRING: err = kvt_pkg::ERR_STR_UNCLOSED;
                SC_CHAR_OPEN, SC_CHAR_ESC, SC_CHAR_CLOSE: err = kvt_pkg::ERR_CHAR_UNCLOSED;
                default: ;
            endcase
            if (err == kvt_pkg::ERR_NONE) push_word(kvt_pkg::CAT_EOF, kvt_pkg::ERR_NONE, 1'b1);
        end
        if (err != kvt_pkg::ERR_NONE) begin
            push_word(kvt_pkg::CAT_EOF, err, 1'b0);
            sc_halted = 1'b1;
        end
        if (fin) clear_state();
        if (step_words.size() > 0) step_words[step_words.size()-1].end_of_run = 1'b1;
        foreach (step_words[i]) expected_tokens = {expected_tokens, step_words[i]};
    endfunction

    // ------------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------------
    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_text_byte  = b;
        s_final_byte = fin;
        do @(posedge aclk); while (!s_ready);
        tokenise_byte(b, fin);
        bytes_sent++;
        if (fin) texts_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    task automatic send_queued_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] word %0d %s: expected %0d, got %0d",
                     $realtime, tokens_checked, what, want, got);
    endtask

    // result side: random stall before each word
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // scoreboard: every word against the oldest expectation
    always @(posedge aclk) begin
        kvt_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("arrived with nothing expected, category", 0, m_category);
            end else begin
                want = expected_tokens.pop_front();
                if (m_category !== want.category)
                    report_mismatch("category", want.category, m_category);
                if (m_error_code !== want.error_code)
                    report_mismatch("error_code", want.error_code, m_error_code);
                if (m_line_number !== want.line_number)
                    report_mismatch("line_number", want.line_number, m_line_number);
                if (m_start_column !== want.start_column)
                    report_mismatch("start_column", want.start_column, m_start_column);
                if (m_token_length !== want.token_length)
                    report_mismatch("token_length", want.token_length, m_token_length);
                if (m_end_of_text !== want.end_of_text)
                    report_mismatch("end_of_text", want.end_of_text, m_end_of_text);
                if (m_end_of_run !== want.end_of_run)
                    report_mismatch("end_of_run", want.end_of_run, m_end_of_run);
            end
            tokens_checked++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_tokens.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Random text builder
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return kvt_pkg::CH_UNDER;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        text_bytes = {text_bytes, b};
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_separator();
        case ($urandom_range(0, 4))
            0:       add_byte(kvt_pkg::CH_COMMA);
            1:       add_byte(kvt_pkg::CH_LF);
            2:       add_byte(kvt_pkg::CH_COLON);
            default: add_byte(kvt_pkg::CH_SPACE);
        endcase
    endfunction

    // mostly well-formed tokens with random content, some noise and breakage
    function automatic void compose_text();
        int         n_tok;
        int         n;
        logic [7:0] b;
        text_bytes.delete();
        n_tok = $urandom_range(2, 10);
        for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    add_byte(rand_letter());
                    n = $urandom_range(0, 6);
                    for (int i = 0; i < n; i++)
                        if ($urandom_range(0, 2) == 0)
                            add_byte(8'("0" + $urandom_range(0, 9)));
                        else
                            add_byte(rand_letter());
                    if ($urandom_range(0, 9) < 7) add_separator();
                end
                3, 4: begin
                    case ($urandom_range(0, 7))
                        0: add_str("true");
                        1: add_str("false");
                        2: add_str("null");
                        3: add_str("tru");
                        4: add_str("nulls");
                        5: add_str("falsey");
                        6: add_str("True");
                        default: add_str("nul_l");
                    endcase
                    if ($urandom_range(0, 9) < 7) add_separator();
                end
                5, 6, 7: begin
                    if ($urandom_range(0, 3) == 0) add_byte(kvt_pkg::CH_MINUS);
                    if ($urandom_range(0, 5) == 0) begin
                        add_byte(kvt_pkg::CH_DOT);
                        n = $urandom_range(0, 3);
                    end else begin
                        n = $urandom_range(1, 4);
                        for (int i = 0; i < n; i++)
                            add_byte(8'("0" + $urandom_range(0, 9)));
                        if ($urandom_range(0, 1) == 0) add_byte(kvt_pkg::CH_DOT);
                        n = $urandom_range(0, 3);
                    end
                    for (int i = 0; i < n; i++)
                        add_byte(8'("0" + $urandom_range(0, 9)));
                    case ($urandom_range(0, 5))
                        0: add_byte("f");
                        1: add_byte("F");
                        2: add_byte("d");
                        3: add_byte("D");
                        default: ;
                    endcase
                    if ($urandom_range(0, 9) < 7) add_separator();
                end
                8, 9: begin
                    add_byte(kvt_pkg::CH_DQUOTE);
                    n = $urandom_range(0, 6);
                    b = 8'h00;
                    for (int i = 0; i < n; i++) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == kvt_pkg::CH_DQUOTE) add_byte(kvt_pkg::CH_BSLASH);
                        add_byte(b);
                    end
                    // a trailing backslash would swallow the closing quote
                    if (b == kvt_pkg::CH_BSLASH) add_byte("x");
                    add_byte(kvt_pkg::CH_DQUOTE);
                end
                10: begin
                    b = 8'($urandom_range(32, 255));
                    add_byte(kvt_pkg::CH_SQUOTE);
                    if (b == kvt_pkg::CH_BSLASH) begin
                        add_byte(kvt_pkg::CH_BSLASH);
                        add_byte(kvt_pkg::CH_SQUOTE);
                    end else begin
                        add_byte(b);
                    end
                    add_byte(kvt_pkg::CH_SQUOTE);
                end
                11, 12, 13: begin
                    case ($urandom_range(0, 4))
                        0: add_byte(kvt_pkg::CH_LBRACK);
                        1: add_byte(kvt_pkg::CH_RBRACK);
                        2: add_byte(kvt_pkg::CH_SEMI);
                        3: add_byte(kvt_pkg::CH_COLON);
                        default: add_byte(kvt_pkg::CH_COMMA);
                    endcase
                end
                14, 15: begin
                    case ($urandom_range(0, 3))
                        0: add_byte(kvt_pkg::CH_SPACE);
                        1: add_byte(kvt_pkg::CH_TAB);
                        2: add_byte(kvt_pkg::CH_CR);
                        default: add_byte(kvt_pkg::CH_LF);
                    endcase
                end
                16: begin
                    add_byte(kvt_pkg::CH_HASH);
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++)
                        add_byte(8'($urandom_range(32, 255)));
                    if ($urandom_range(0, 4) != 0) add_byte(kvt_pkg::CH_LF);
                end
                17: add_byte(8'($urandom_range(0, 255)));
                18: begin
                    case ($urandom_range(0, 3))
                        0: add_str("\"unterminated");
                        1: add_str("'\\q");
                        2: add_str("'ab");
                        default: add_str("3..1");
                    endcase
                end
                default: add_str("'\\''");
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_keys_and_delimiters();
        // keywords, near misses, case sensitivity, every delimiter
        send_text("[true,nul;null:false,falsex _T9 True]", 1'b1);
    endtask

    task automatic test_numbers();
        // sign, leading dot, suffixes, suffix ending a number, flush at end
        send_text("-7 .5,3.25f 8D -.F 9d1 42", 1'b1);
        // second dot halts the text; later bytes are ignored
        send_text("1..5 x", 1'b1);
    endtask

    task automatic test_strings();
        // escaped quote, escaped backslash still escaping, newline inside,
        // then a string left open by the final byte
        send_text("\"a\\\"b\\\\\" x\" \"l1\nl2\" \"open", 1'b1);
    endtask

    task automatic test_char_literals();
        send_text("'a' '\\'' 'q", 1'b1);  // last one left open
        send_text("'\\x' ;", 1'b1);       // bad escape
        send_text("'ab' ", 1'b1);         // missing closing quote
        send_text("'\\", 1'b1);           // open after the backslash
        send_text("'", 1'b1);
    endtask

    task automatic test_invalid_bytes();
        send_byte(8'h01, 1'b0);
        send_byte("a", 1'b0);             // ignored while halted
        send_byte(8'h80, 1'b1);           // only ends the text
        send_byte(8'hFF, 1'b1);           // error and end on the same byte
        send_text(" ", 1'b1);             // nothing but EOF
    endtask

    task automatic test_comments_and_lines();
        send_text("k # note\n\tb", 1'b0);
        send_byte(kvt_pkg::CH_CR, 1'b0);
        send_text("\n c#open", 1'b1);     // final byte inside a comment
    endtask

    task automatic test_random_texts();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            compose_text();
            send_queued_text();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_text_byte    = 8'h00;
        s_final_byte   = 1'b0;
        mismatch_count = 0;
        tokens_checked = 0;
        bytes_sent     = 0;
        texts_sent     = 0;
        cycle_count    = 0;
        clear_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_keys_and_delimiters();
        test_numbers();
        test_strings();
        test_char_literals();
        test_invalid_bytes();
        test_comments_and_lines();
        test_random_texts();

        s_valid = 1'b0;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_tokens.size() != 0)
            report_mismatch("words never delivered", 0, expected_tokens.size());

        $display("Scanned %0d bytes in %0d texts; %0d result words compared.",
                 bytes_sent, texts_sent, tokens_checked);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
